/* src/qpt_pkg.sv */
// shared types, constants and the divider step for the quaternion pose block
package qpt_pkg;

  localparam int QW   = 16;  // quaternion component width
  localparam int PW   = 24;  // position width
  localparam int TW   = 28;  // translation width
  localparam int RW   = 16;  // rotation element width
  localparam int PRW  = 32;  // product width
  localparam int SW   = 34;  // signed numerator width
  localparam int NW   = 33;  // squared norm and magnitude width
  localparam int QB   = 15;  // quotient bits
  localparam int DW   = NW + 1;        // doubled norm
  localparam int REMW = NW + QB + 1;   // partial remainder
  localparam int NE   = 9;   // rotation elements
  localparam int NP   = 3;   // position axes

  localparam logic [RW-1:0] ONE_Q14 = RW'(16384);

  // item handed from front to back: magnitudes and signs of the numerators
  typedef struct packed {
    logic [NE-1:0][NW-1:0] mag;
    logic [NE-1:0]         neg;
    logic [NW-1:0]         norm;
    logic                  zero;
    logic [NP-1:0][TW-1:0] trans;
  } work_t;

  // item in flight inside the divider pipeline
  typedef struct packed {
    logic [NE-1:0][REMW-1:0] rem;
    logic [NE-1:0][QB-1:0]   quo;
    logic [DW-1:0]           dvs;
    logic [NE-1:0]           neg;
    logic                    zero;
    logic [NP-1:0][TW-1:0]   trans;
  } div_t;

  // one restoring division step on all nine lanes, quotient bit k
  function automatic div_t div_step(div_t cur, int k);
    div_t nxt;
    logic [REMW-1:0] trial;
    nxt   = cur;
    trial = REMW'(cur.dvs) << k;
    for (int e = 0; e < NE; e++) begin
      if (cur.rem[e] >= trial) begin
        nxt.rem[e]    = cur.rem[e] - trial;
        nxt.quo[e][k] = 1'b1;
      end
    end
    return nxt;
  endfunction

endpackage

/* src/quaternion_pose_to_transform.sv */
// top level: quaternion pose to 3x3 rotation and millimetre translation
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, quat_w..z, pos_x..z  | in
//  output  | out_valid, out_stall, rot_00..22, trans_* | out
//
// one pose per cycle sustained while out_stall is low; the path is 2 front stages,
// the queue and 17 back stages (setup, 15 divider bits, output register)
// the 15-stage restoring divider, one quotient bit per stage, sets the depth
// rst is synchronous; it clears every valid bit and the queue pointers
// out_stall backs up the divider stages, then the queue, then the front
// a bubble anywhere in a pipe is filled while downstream is stalled
module quaternion_pose_to_transform #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] rot_00,
  output logic signed [15:0] rot_01,
  output logic signed [15:0] rot_02,
  output logic signed [15:0] rot_10,
  output logic signed [15:0] rot_11,
  output logic signed [15:0] rot_12,
  output logic signed [15:0] rot_20,
  output logic signed [15:0] rot_21,
  output logic signed [15:0] rot_22,
  output logic signed [27:0] trans_x,
  output logic signed [27:0] trans_y,
  output logic signed [27:0] trans_z
);
  import qpt_pkg::*;

  // front to queue transfer
  logic  f_valid, f_stall;
  work_t f_item;
  // queue to back transfer
  logic  q_valid, q_stall;
  logic [$bits(work_t)-1:0] q_data;
  work_t q_item;

  logic [NE-1:0][RW-1:0] rot;
  logic [NP-1:0][TW-1:0] trans;

  qpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .out_valid (f_valid),
    .out_stall (f_stall),
    .out_item  (f_item)
  );

  // decouples the product front end from the long divider
  qpt_fifo #(
    .W     ($bits(work_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_data   (f_item),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .out_data  (q_data)
  );

  assign q_item = work_t'(q_data);

  qpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_stall  (q_stall),
    .in_item   (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rot       (rot),
    .trans     (trans)
  );

  // row-major element order from the back end
  assign rot_00  = rot[0];
  assign rot_01  = rot[1];
  assign rot_02  = rot[2];
  assign rot_10  = rot[3];
  assign rot_11  = rot[4];
  assign rot_12  = rot[5];
  assign rot_20  = rot[6];
  assign rot_21  = rot[7];
  assign rot_22  = rot[8];
  assign trans_x = trans[0];
  assign trans_y = trans[1];
  assign trans_z = trans[2];

endmodule

/* src/qpt_front.sv */
// front end: products, norm, numerator magnitudes and scaled position
module qpt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    quat_w,
  input  logic signed [15:0]    quat_x,
  input  logic signed [15:0]    quat_y,
  input  logic signed [15:0]    quat_z,
  input  logic signed [23:0]    pos_x,
  input  logic signed [23:0]    pos_y,
  input  logic signed [23:0]    pos_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qpt_pkg::work_t        out_item
);
  import qpt_pkg::*;

  logic va, vb, rdy_a, rdy_b;
  logic signed [PRW-1:0] ww, xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [NP-1:0][PW-1:0] pos;
  work_t item, item_next;

  assign rdy_b    = !vb || !out_stall;
  assign rdy_a    = !va || rdy_b;
  assign in_stall = !rdy_a;
  assign out_valid = vb;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
    end
  end

  // stage a: ten products
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      ww <= quat_w * quat_w;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;
      xz <= quat_x * quat_z;
      yz <= quat_y * quat_z;
      xw <= quat_x * quat_w;
      yw <= quat_y * quat_w;
      zw <= quat_z * quat_w;
      pos[0] <= pos_x;
      pos[1] <= pos_y;
      pos[2] <= pos_z;
    end
  end

  // stage b: sums and sign split
  always_comb begin
    logic signed [SW-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_xw, e_yw, e_zw;
    logic signed [NE-1:0][SW-1:0] num;
    logic signed [SW-1:0] nsum;
    logic signed [TW-1:0] p;
    e_ww = SW'(ww); e_xx = SW'(xx); e_yy = SW'(yy); e_zz = SW'(zz);
    e_xy = SW'(xy); e_xz = SW'(xz); e_yz = SW'(yz);
    e_xw = SW'(xw); e_yw = SW'(yw); e_zw = SW'(zw);
    num[0] = e_ww + e_xx - e_yy - e_zz;
    num[1] = (e_xy - e_zw) <<< 1;
    num[2] = (e_xz + e_yw) <<< 1;
    num[3] = (e_xy + e_zw) <<< 1;
    num[4] = e_ww - e_xx + e_yy - e_zz;
    num[5] = (e_yz - e_xw) <<< 1;
    num[6] = (e_xz - e_yw) <<< 1;
    num[7] = (e_yz + e_xw) <<< 1;
    num[8] = e_ww - e_xx - e_yy + e_zz;
    nsum = e_ww + e_xx + e_yy + e_zz;
    item_next.norm = nsum[NW-1:0];
    item_next.zero = (nsum == '0);
    for (int e = 0; e < NE; e++) begin
      item_next.neg[e] = num[e][SW-1];
      item_next.mag[e] = num[e][SW-1] ? NW'(-num[e]) : NW'(num[e]);
    end
    for (int a = 0; a < NP; a++) begin
      // element select is unsigned, so sign-extend explicitly
      p = TW'($signed(pos[a]));
      item_next.trans[a] = (p <<< 3) + (p <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) item <= item_next;
  end

  a_hold_b: assert property (@(posedge clk) disable iff (rst)
    vb && out_stall |=> vb && $stable(item.norm))
    else $error("front lost a stalled item");

endmodule

/* src/qpt_fifo.sv */
// short flop queue between front and back
module qpt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][W-1:0] mem;
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push, pop;

  assign in_stall  = (count == CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count past depth");

endmodule

/* src/qpt_back.sv */
// back end: pipelined restoring divider, sign and identity fix-up
module qpt_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  qpt_pkg::work_t                   in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [qpt_pkg::NE-1:0][qpt_pkg::RW-1:0] rot,
  output logic [qpt_pkg::NP-1:0][qpt_pkg::TW-1:0] trans
);
  import qpt_pkg::*;

  div_t st [QB+1];
  logic [QB:0] v;
  logic [QB:0] rdy;
  logic ro;
  div_t setup;

  assign ro       = !out_valid || !out_stall;
  assign rdy[QB]  = !v[QB] || ro;
  assign in_stall = !rdy[0];

  // dividend (2*mag*2^14 + n) over divisor 2n rounds half away from zero
  always_comb begin
    setup.dvs   = {in_item.norm, 1'b0};
    setup.neg   = in_item.neg;
    setup.zero  = in_item.zero;
    setup.trans = in_item.trans;
    for (int e = 0; e < NE; e++) begin
      setup.rem[e] = REMW'({in_item.mag[e], {QB{1'b0}}}) + REMW'(in_item.norm);
      setup.quo[e] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (rdy[0]) v[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (rdy[0]) st[0] <= setup;
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    assign rdy[s] = !v[s] || rdy[s+1];
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (rdy[s+1]) v[s+1] <= v[s];
    end
    always_ff @(posedge clk) begin
      if (rdy[s+1]) st[s+1] <= div_step(st[s], QB - 1 - s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ro) out_valid <= v[QB];
  end

  always_ff @(posedge clk) begin
    if (ro) begin
      for (int e = 0; e < NE; e++) begin
        if (st[QB].zero)
          rot[e] <= (e == 0 || e == 4 || e == 8) ? ONE_Q14 : '0;
        else if (st[QB].neg[e])
          rot[e] <= -RW'(st[QB].quo[e]);
        else
          rot[e] <= RW'(st[QB].quo[e]);
      end
      trans <= st[QB].trans;
    end
  end

  logic rot_ok, rem_ok;
  always_comb begin
    rot_ok = 1'b1;
    rem_ok = 1'b1;
    for (int e = 0; e < NE; e++) begin
      if ($signed(rot[e]) > $signed(ONE_Q14) || $signed(rot[e]) < -$signed(ONE_Q14))
        rot_ok = 1'b0;
      if (!st[QB].zero && st[QB].rem[e] >= REMW'(st[QB].dvs))
        rem_ok = 1'b0;
    end
  end

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rot_ok)
    else $error("rotation element out of range");

  a_conv: assert property (@(posedge clk) disable iff (rst)
    v[QB] |-> rem_ok)
    else $error("divider remainder not below divisor");

endmodule
